@@ rtl/bfd_pkg.sv @@
// Shared types and constants for the binary fraction to decimal converter.
`timescale 1ns / 1ps
`default_nettype none
package bfd_pkg;
    localparam int unsigned POINT_POS = 23;
    localparam int unsigned COEF_W    = 96;
    localparam int unsigned SIG_W     = 24;
    localparam int unsigned EXP_W     = 8;
    localparam int unsigned SCALE_W   = 5;
    localparam int unsigned K_W       = 9;

    // Operation requested of the serial arithmetic unit
    typedef enum logic [2:0] {
        OP_NONE = 3'b001,
        OP_MUL5 = 3'b010,
        OP_DIV10 = 3'b100
    } t_op;
endpackage
`default_nettype wire

@@ rtl/binary_fraction_to_decimal_scaled.sv @@
// Top level: stream wrapper and sequencer of the decimal conversion.
//
// Slave channel: s_axis_tdata carries significand (bits 23:0) and exponent
// (bits 31:24, two's complement). Master channel: m_axis_tdata carries
// coefficient_low, coefficient_mid, coefficient_high, decimal_scale from
// bit 0 upwards, zero-filled to 104 bits.
// One item is worked at a time. With k = 23 - exponent, the serial unit
// runs k multiply-by-five passes and max(k - MAX_SCALE, 0) divide-by-ten
// passes, each through a one-bit datapath, then the rounding and output
// states follow; for k <= 0 the passes are skipped and the item goes
// straight to rounding.
// The result sits in an output register; s_axis_tready rises again as soon
// as it is loaded, so a new transaction is taken while the result waits.
// A stalled receiver holds the result; work on the next item stops at its
// end until the output register is free. Reset clears the state, valid and wait flags.
`timescale 1ns / 1ps
`default_nettype none
module binary_fraction_to_decimal_scaled #(
    parameter int unsigned MAX_SCALE  = 28,
    parameter int unsigned WORK_WIDTH = 320
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,  // significand[23:0], exponent[31:24]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata   // coef low, mid, high, scale[100:96]
);
    import bfd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_RND  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [K_W-1:0]      r_left, n_left;
    logic [SCALE_W-1:0]  r_scale, n_scale;
    logic                r_sticky, n_sticky;
    logic [3:0]          r_last, n_last;
    logic                r_wait, n_wait;
    logic                r_ovalid, n_ovalid;
    logic [103:0]        r_odata, n_odata;
    logic                w_load;
    t_op                 w_op;
    logic                w_done;
    logic [3:0]          w_rem;
    logic [WORK_WIDTH-1:0] w_work;
    logic signed [K_W-1:0] w_k;
    logic [COEF_W-1:0]   w_coef;
    logic                w_up;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_load = s_axis_tvalid && s_axis_tready;
    assign w_k = K_W'(POINT_POS) - {s_axis_tdata[31], s_axis_tdata[31:24]};
    assign w_coef = w_work[COEF_W-1:0];
    assign w_up = (r_last > 4'd5) ||
                  (r_last == 4'd5 && (r_sticky || w_coef[0]));

    bfd_serial_unit #(.WORK_WIDTH(WORK_WIDTH)) u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_load),
        .i_sig  (s_axis_tdata[SIG_W-1:0]),
        .i_op   (w_op),
        .o_done (w_done),
        .o_rem  (w_rem),
        .o_work (w_work)
    );

    // Sequence the passes and round
    always_comb begin
        n_state  = r_state;
        n_left   = r_left;
        n_scale  = r_scale;
        n_sticky = r_sticky;
        n_last   = r_last;
        n_wait   = r_wait;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        w_op     = OP_NONE;
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_load) begin
                    n_sticky = 1'b0;
                    n_last   = '0;
                    n_wait   = 1'b0;
                    if (w_k <= 0) begin
                        n_scale = '0;
                        n_left  = '0;
                        n_state = S_RND;
                    end else begin
                        n_left  = K_W'(w_k);
                        n_scale = SCALE_W'(w_k > K_W'(MAX_SCALE) ? MAX_SCALE
                                                                 : w_k);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (!r_wait) begin
                    w_op   = OP_MUL5;
                    n_wait = 1'b1;
                end else if (w_done) begin
                    n_wait = 1'b0;
                    n_left = r_left - 1'b1;
                    if (r_left == K_W'(1)) n_state = S_RND;
                end
            end
            S_DIV: begin
                if (!r_wait) begin
                    w_op   = OP_DIV10;
                    n_wait = 1'b1;
                end else if (w_done) begin
                    n_wait = 1'b0;
                    if (r_last != 4'd0) n_sticky = 1'b1;
                    n_last = w_rem;
                    n_left = r_left - 1'b1;
                    if (r_left == K_W'(1)) n_state = S_RND;
                end
            end
            S_RND: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {3'b000, r_scale,
                                w_coef + (w_up ? COEF_W'(1) : COEF_W'(0))};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Divide passes needed after multiplying, latched at accept
    logic [K_W-1:0] r_ndiv;
    always_ff @(posedge i_clk) begin
        if (w_load)
            r_ndiv <= (w_k > K_W'(MAX_SCALE)) ? K_W'(w_k - K_W'(MAX_SCALE)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            r_wait   <= n_wait;
            if (r_state == S_MUL && n_state == S_RND && r_ndiv != '0)
                r_state <= S_DIV;
            else
                r_state <= n_state;
        end
        r_left   <= (r_state == S_MUL && n_state == S_RND && r_ndiv != '0) ? r_ndiv
                    : n_left;
        r_scale  <= n_scale;
        r_sticky <= n_sticky;
        r_last   <= n_last;
        r_odata  <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_odata));
    endproperty
    a_hold: assert property (p_hold) else $error("output changed");
    property p_scale;
        @(posedge i_clk) disable iff (!i_rst_n)
            m_axis_tvalid |-> (m_axis_tdata[100:96] <= SCALE_W'(MAX_SCALE));
    endproperty
    a_scale: assert property (p_scale) else $error("scale out of range");
    property p_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state != S_IDLE) |-> !s_axis_tready;
    endproperty
    a_busy: assert property (p_busy) else $error("ready while busy");
    property p_accept;
        @(posedge i_clk) disable iff (!i_rst_n)
            (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE);
    endproperty
    a_accept: assert property (p_accept) else $error("accept lost");
endmodule
`default_nettype wire

@@ rtl/bfd_serial_unit.sv @@
// Bit-serial multiply-by-five and divide-by-ten unit over the working value.
`timescale 1ns / 1ps
`default_nettype none
module bfd_serial_unit #(
    parameter int unsigned WORK_WIDTH = 320
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire logic [bfd_pkg::SIG_W-1:0] i_sig,
    input  wire bfd_pkg::t_op          i_op,
    output logic                       o_done,
    output logic [3:0]                 o_rem,
    output logic [WORK_WIDTH-1:0]      o_work
);
    import bfd_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORK_WIDTH + 1);

    logic [WORK_WIDTH-1:0] r_work, n_work;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic [2:0]            r_carry, n_carry;
    logic [3:0]            r_rem, n_rem;
    logic                  r_done, n_done;
    t_op                   r_op, n_op;
    logic [4:0]            w_rem2;
    logic [3:0]            w_sum;

    // One bit per cycle: LSB-first rotate for x5, MSB-first rotate for /10
    always_comb begin
        n_work  = r_work;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_carry = r_carry;
        n_rem   = r_rem;
        n_done  = 1'b0;
        n_op    = r_op;
        w_sum   = {1'b0, r_work[0], 2'b00} + {3'b000, r_work[0]}
                  + {1'b0, r_carry};
        w_rem2  = {r_rem, r_work[WORK_WIDTH-1]};
        if (i_load) begin
            n_work = {{(WORK_WIDTH-SIG_W){1'b0}}, i_sig};
            n_busy = 1'b0;
        end else if (!r_busy && i_op != OP_NONE) begin
            n_busy  = 1'b1;
            n_op    = i_op;
            n_cnt   = '0;
            n_carry = '0;
            n_rem   = '0;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL5: begin
                    n_work  = {w_sum[0], r_work[WORK_WIDTH-1:1]};
                    n_carry = w_sum[3:1];
                end
                OP_DIV10: begin
                    if (w_rem2 >= 5'd10) begin
                        n_rem  = 4'(w_rem2 - 5'd10);
                        n_work = {r_work[WORK_WIDTH-2:0], 1'b1};
                    end else begin
                        n_rem  = w_rem2[3:0];
                        n_work = {r_work[WORK_WIDTH-2:0], 1'b0};
                    end
                end
                default: ;
            endcase
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(WORK_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_NONE;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
        end
        r_work  <= n_work;
        r_cnt   <= n_cnt;
        r_carry <= n_carry;
        r_rem   <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_work = r_work;
endmodule
`default_nettype wire
